FILE: sv/ifsf_pkg.sv
package ifsf_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_IDX_W = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FLAG = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ADDRESS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_SEQ0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_SEQ1 = 3'd5;

    localparam logic [BYTE_W-1:0] FLAG_RESET = 8'h7E;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h7D;
    localparam logic [BYTE_W-1:0] MASK_RESET = 8'h20;
    localparam logic [BYTE_W-1:0] ADDRESS_RESET = 8'h03;
    localparam logic [BYTE_W-1:0] CTRL_SEQ0_RESET = 8'h00;
    localparam logic [BYTE_W-1:0] CTRL_SEQ1_RESET = 8'h40;
    localparam logic [BYTE_W-1:0] BCC_INIT = 8'h00;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [BYTE_W-1:0] flag_byte;
        logic [BYTE_W-1:0] escape_byte;
        logic [BYTE_W-1:0] escape_mask;
        logic [BYTE_W-1:0] address_byte;
        logic [BYTE_W-1:0] control_seq0;
        logic [BYTE_W-1:0] control_seq1;
    } cfg_t;

    // one classified payload byte, with the check byte the frame has reached
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              first;
        logic              last;
        logic              seq;
        logic [BYTE_W-1:0] bcc;
    } cmd_t;

endpackage

FILE: sv/ifsf_ifs.sv
interface ifsf_in_if;
    logic                          valid;
    logic                          ready;
    logic [ifsf_pkg::BYTE_W-1:0]   data_byte;
    logic                          first_byte;
    logic                          last_byte;
    logic                          sequence_req;

    modport source (output valid, output data_byte, output first_byte,
                    output last_byte, output sequence_req, input ready);
    modport sink (input valid, input data_byte, input first_byte,
                  input last_byte, input sequence_req, output ready);
endinterface

interface ifsf_out_if;
    logic                          valid;
    logic                          ready;
    logic [ifsf_pkg::BYTE_W-1:0]   out_byte;
    logic                          run_last;
    logic                          frame_end;

    modport source (output valid, output out_byte, output run_last,
                    output frame_end, input ready);
    modport sink (input valid, input out_byte, input run_last,
                  input frame_end, output ready);
endinterface

interface ifsf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ifsf_pkg::CFG_IDX_W-1:0]  index;
    logic [ifsf_pkg::BYTE_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/ifsf_front.sv
// Accepts payload requests, keeps the running XOR and builds commands.
module ifsf_front
(
    input  logic             clk,
    input  logic             rst_n,
    ifsf_in_if.sink          in_ch,
    input  logic             q_full,
    output logic             push,
    output ifsf_pkg::cmd_t   push_cmd
);

    logic [ifsf_pkg::BYTE_W-1:0] parity_reg;
    logic [ifsf_pkg::BYTE_W-1:0] parity_next;
    logic [ifsf_pkg::BYTE_W-1:0] base;
    logic [ifsf_pkg::BYTE_W-1:0] bcc;

    assign in_ch.ready = !q_full;
    assign push = in_ch.valid && !q_full;

    always_comb
    begin
        base = in_ch.first_byte ? ifsf_pkg::BCC_INIT : parity_reg;
        bcc = base ^ in_ch.data_byte;
        parity_next = in_ch.last_byte ? ifsf_pkg::BCC_INIT : bcc;
        push_cmd.data = in_ch.data_byte;
        push_cmd.first = in_ch.first_byte;
        push_cmd.last = in_ch.last_byte;
        push_cmd.seq = in_ch.sequence_req;
        push_cmd.bcc = bcc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg <= ifsf_pkg::BCC_INIT;
        end
        else if (push)
        begin
            parity_reg <= parity_next;
        end
    end

endmodule

FILE: sv/ifsf_queue.sv
// Small command queue between front and back.
module ifsf_queue
#(
    parameter int DEPTH = ifsf_pkg::QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ifsf_pkg::cmd_t   push_cmd,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output ifsf_pkg::cmd_t   head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ifsf_pkg::cmd_t     mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_cmd = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count out of range");

endmodule

FILE: sv/ifsf_back.sv
// Byte sequencer: header, stuffed payload, stuffed check, closing flag.
module ifsf_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  ifsf_pkg::cfg_t   cfg,
    input  logic             head_valid,
    input  ifsf_pkg::cmd_t   head_cmd,
    output logic             pop,
    ifsf_out_if.source       out_ch
);

    localparam logic [3:0] ST_START = 4'd0;
    localparam logic [3:0] ST_HFLAG = 4'd1;
    localparam logic [3:0] ST_HADDR = 4'd2;
    localparam logic [3:0] ST_HCTRL = 4'd3;
    localparam logic [3:0] ST_HCHK = 4'd4;
    localparam logic [3:0] ST_DATA = 4'd5;
    localparam logic [3:0] ST_DATA2 = 4'd6;
    localparam logic [3:0] ST_CHK = 4'd7;
    localparam logic [3:0] ST_CHK2 = 4'd8;
    localparam logic [3:0] ST_CLOSE = 4'd9;

    logic [3:0]                    st_reg;
    logic [3:0]                    st_next;
    logic [3:0]                    cur_st;
    logic                          done;
    logic                          advance;
    logic [ifsf_pkg::BYTE_W-1:0]   ctrl;
    logic                          esc_data;
    logic                          esc_chk;
    logic [ifsf_pkg::BYTE_W-1:0]   byte_next;
    logic                          end_next;

    logic                          out_valid_reg;
    logic [ifsf_pkg::BYTE_W-1:0]   out_byte_reg;
    logic                          run_last_reg;
    logic                          frame_end_reg;

    assign advance = head_valid && (!out_valid_reg || out_ch.ready);
    assign pop = advance && done;

    always_comb
    begin
        ctrl = head_cmd.seq ? cfg.control_seq1 : cfg.control_seq0;
        esc_data = (head_cmd.data == cfg.flag_byte) || (head_cmd.data == cfg.escape_byte);
        esc_chk = (head_cmd.bcc == cfg.flag_byte) || (head_cmd.bcc == cfg.escape_byte);
        if (st_reg == ST_START)
        begin
            cur_st = head_cmd.first ? ST_HFLAG : ST_DATA;
        end
        else
        begin
            cur_st = st_reg;
        end
        byte_next = cfg.flag_byte;
        end_next = 1'b0;
        done = 1'b0;
        st_next = ST_START;
        unique case (cur_st)
            ST_HFLAG:
            begin
                byte_next = cfg.flag_byte;
                st_next = ST_HADDR;
            end
            ST_HADDR:
            begin
                byte_next = cfg.address_byte;
                st_next = ST_HCTRL;
            end
            ST_HCTRL:
            begin
                byte_next = ctrl;
                st_next = ST_HCHK;
            end
            ST_HCHK:
            begin
                byte_next = cfg.address_byte ^ ctrl;
                st_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (esc_data)
                begin
                    byte_next = cfg.escape_byte;
                    st_next = ST_DATA2;
                end
                else
                begin
                    byte_next = head_cmd.data;
                    st_next = ST_CHK;
                    done = !head_cmd.last;
                end
            end
            ST_DATA2:
            begin
                byte_next = head_cmd.data ^ cfg.escape_mask;
                st_next = ST_CHK;
                done = !head_cmd.last;
            end
            ST_CHK:
            begin
                if (esc_chk)
                begin
                    byte_next = cfg.escape_byte;
                    st_next = ST_CHK2;
                end
                else
                begin
                    byte_next = head_cmd.bcc;
                    st_next = ST_CLOSE;
                end
            end
            ST_CHK2:
            begin
                byte_next = head_cmd.bcc ^ cfg.escape_mask;
                st_next = ST_CLOSE;
            end
            ST_CLOSE:
            begin
                byte_next = cfg.flag_byte;
                end_next = 1'b1;
                done = 1'b1;
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_START;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            st_reg <= done ? ST_START : st_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= byte_next;
            run_last_reg <= done;
            frame_end_reg <= end_next;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.run_last = run_last_reg;
    assign out_ch.frame_end = frame_end_reg;

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_end_reg |-> run_last_reg)
        else $error("closing flag not marked as last of its request");

    a_pop_resets_seq: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> st_reg == ST_START)
        else $error("sequencer not back at start after pop");

    a_mid_cmd_head: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg != ST_START |-> head_valid)
        else $error("sequencer mid-request with empty queue");

endmodule

FILE: sv/info_frame_stuffing_framer.sv
// Information-frame byte-stuffing framer. Each payload request on in_ch
// yields one or more bytes on out_ch: a first byte brings a four-byte header
// (flag, address, control, address^control), a byte equal to the flag or
// escape value goes out as escape then byte^mask, and a last byte appends the
// stuffed XOR check and a closing flag (frame_end). run_last marks the final
// byte of each request. Output is one byte per cycle while the receiver is
// ready and a request is queued, set by the single output register; a request
// yields 1 to 9 bytes (2 for a stuffed mid-frame byte); a short queue lets
// further requests be taken while earlier ones are still being sent. Registers
// are written through cfg (index 0 flag, 1 escape, 2 mask, 3 address, 4 control
// seq0, 5 control seq1) by the user only while the block is idle, which the
// block does not enforce; the port is always ready and other indexes are ignored.
module info_frame_stuffing_framer
#(
    parameter int QUEUE_DEPTH = ifsf_pkg::QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    ifsf_in_if.sink      in_ch,
    ifsf_out_if.source   out_ch,
    ifsf_cfg_if.sink     cfg
);

    ifsf_pkg::cfg_t   cfg_reg;
    ifsf_pkg::cmd_t   push_cmd;
    ifsf_pkg::cmd_t   head_cmd;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             head_valid;

    // configuration registers; writes always land at once
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_byte <= ifsf_pkg::FLAG_RESET;
            cfg_reg.escape_byte <= ifsf_pkg::ESCAPE_RESET;
            cfg_reg.escape_mask <= ifsf_pkg::MASK_RESET;
            cfg_reg.address_byte <= ifsf_pkg::ADDRESS_RESET;
            cfg_reg.control_seq0 <= ifsf_pkg::CTRL_SEQ0_RESET;
            cfg_reg.control_seq1 <= ifsf_pkg::CTRL_SEQ1_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                ifsf_pkg::REG_FLAG:      cfg_reg.flag_byte <= cfg.data;
                ifsf_pkg::REG_ESCAPE:    cfg_reg.escape_byte <= cfg.data;
                ifsf_pkg::REG_MASK:      cfg_reg.escape_mask <= cfg.data;
                ifsf_pkg::REG_ADDRESS:   cfg_reg.address_byte <= cfg.data;
                ifsf_pkg::REG_CTRL_SEQ0: cfg_reg.control_seq0 <= cfg.data;
                ifsf_pkg::REG_CTRL_SEQ1: cfg_reg.control_seq1 <= cfg.data;
                default:
                begin
                    // unused index: write dropped
                end
            endcase
        end
    end

    // front: take request, update check, classify
    ifsf_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // decoupling queue
    ifsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // back: byte sequencer and output register
    ifsf_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule

FILE: test/ifsf_checker.sv
`timescale 1ns / 100ps

// Watches the three channels, keeps its own copy of the link registers and the
// running check byte, and compares every output byte with the oldest one owed.
module ifsf_checker
(
    input  logic clk,
    input  logic rst_n,
    ifsf_in_if   in_mon,
    ifsf_out_if  out_mon,
    ifsf_cfg_if  cfg_mon,
    output int   fault_count,
    output int   bytes_owed,
    output int   bytes_seen,
    output int   frames_closed
);

    typedef struct packed {
        logic [ifsf_pkg::BYTE_W-1:0] out_byte;
        logic                        run_last;
        logic                        frame_end;
    } line_byte_t;

    ifsf_pkg::cfg_t              link_cfg;
    logic [ifsf_pkg::BYTE_W-1:0] frame_xor;
    line_byte_t                  owed_q[$];
    int                          faults;
    int                          seen;
    int                          closed;

    function automatic void emit(logic [ifsf_pkg::BYTE_W-1:0] b, logic fe);
        line_byte_t lb;
        lb.out_byte  = b;
        lb.run_last  = 1'b0;
        lb.frame_end = fe;
        owed_q.push_back(lb);
    endfunction

    function automatic void emit_stuffed(logic [ifsf_pkg::BYTE_W-1:0] b);
        if (b == link_cfg.flag_byte || b == link_cfg.escape_byte)
        begin
            emit(link_cfg.escape_byte, 1'b0);
            emit(b ^ link_cfg.escape_mask, 1'b0);
        end
        else
        begin
            emit(b, 1'b0);
        end
    endfunction

    // bytes one payload request puts on the line
    function automatic void frame_request(logic [ifsf_pkg::BYTE_W-1:0] data, logic first,
                                          logic last, logic seq);
        logic [ifsf_pkg::BYTE_W-1:0] ctrl;
        line_byte_t                  tail;
        ctrl = seq ? link_cfg.control_seq1 : link_cfg.control_seq0;
        if (first)
        begin
            // header is sent raw
            emit(link_cfg.flag_byte, 1'b0);
            emit(link_cfg.address_byte, 1'b0);
            emit(ctrl, 1'b0);
            emit(link_cfg.address_byte ^ ctrl, 1'b0);
            frame_xor = ifsf_pkg::BCC_INIT;
        end
        emit_stuffed(data);
        frame_xor = frame_xor ^ data;
        if (last)
        begin
            emit_stuffed(frame_xor);
            emit(link_cfg.flag_byte, 1'b1);
            frame_xor = ifsf_pkg::BCC_INIT;
        end
        tail = owed_q.pop_back();
        tail.run_last = 1'b1;
        owed_q.push_back(tail);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        line_byte_t want;
        if (!rst_n)
        begin
            link_cfg = '{flag_byte: ifsf_pkg::FLAG_RESET,
                         escape_byte: ifsf_pkg::ESCAPE_RESET,
                         escape_mask: ifsf_pkg::MASK_RESET,
                         address_byte: ifsf_pkg::ADDRESS_RESET,
                         control_seq0: ifsf_pkg::CTRL_SEQ0_RESET,
                         control_seq1: ifsf_pkg::CTRL_SEQ1_RESET};
            frame_xor = ifsf_pkg::BCC_INIT;
            owed_q.delete();
            faults = 0;
            seen   = 0;
            closed = 0;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                seen++;
                if (owed_q.size() == 0)
                begin
                    faults++;
                    if (faults <= 10)
                        $display("%t: unexpected byte %h run_last %b frame_end %b", $time,
                                 out_mon.out_byte, out_mon.run_last, out_mon.frame_end);
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (want.frame_end)
                        closed++;
                    if (want.out_byte !== out_mon.out_byte
                        || want.run_last !== out_mon.run_last
                        || want.frame_end !== out_mon.frame_end)
                    begin
                        faults++;
                        if (faults <= 10)
                            $display("%t: byte %0d exp %h/%b/%b got %h/%b/%b", $time, seen,
                                     want.out_byte, want.run_last, want.frame_end,
                                     out_mon.out_byte, out_mon.run_last, out_mon.frame_end);
                    end
                end
            end
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                unique case (cfg_mon.index)
                    ifsf_pkg::REG_FLAG:      link_cfg.flag_byte    = cfg_mon.data;
                    ifsf_pkg::REG_ESCAPE:    link_cfg.escape_byte  = cfg_mon.data;
                    ifsf_pkg::REG_MASK:      link_cfg.escape_mask  = cfg_mon.data;
                    ifsf_pkg::REG_ADDRESS:   link_cfg.address_byte = cfg_mon.data;
                    ifsf_pkg::REG_CTRL_SEQ0: link_cfg.control_seq0 = cfg_mon.data;
                    ifsf_pkg::REG_CTRL_SEQ1: link_cfg.control_seq1 = cfg_mon.data;
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready)
                frame_request(in_mon.data_byte, in_mon.first_byte, in_mon.last_byte,
                              in_mon.sequence_req);
        end
        fault_count   <= faults;
        bytes_owed    <= owed_q.size();
        bytes_seen    <= seen;
        frames_closed <= closed;
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the framer. Prediction and comparison live in the
// checker beside the block; here we only make requests, pace the channels
// and decide the outcome.
module testbench;

    typedef logic [ifsf_pkg::BYTE_W-1:0] byte_t;

    logic clk;
    logic rst_n;

    ifsf_in_if  in_ch();
    ifsf_out_if out_ch();
    ifsf_cfg_if cfg();

    int faults;
    int owed;
    int bytes_seen;
    int frames_closed;

    int             src_idle;     // percent of cycles the sender holds off
    int             sink_idle;    // percent of cycles the receiver stalls
    int             sent;         // payload requests accepted
    int             settings;     // link settings exercised
    ifsf_pkg::cfg_t cur_cfg;      // what the registers hold now, for picking bytes

    info_frame_stuffing_framer uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch),
        .cfg   (cfg)
    );

    ifsf_checker chk
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .cfg_mon      (cfg),
        .fault_count  (faults),
        .bytes_owed   (owed),
        .bytes_seen   (bytes_seen),
        .frames_closed(frames_closed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop well past the slowest legal run (9 bytes per request, long stalls)
    initial
    begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: ready redrawn every cycle from the current stall rate
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(99) >= sink_idle);
        end
    end

    // One payload request. Random hold-off first, then wait for the handshake.
    // valid is left high on return so back-to-back requests need no dip.
    task automatic send_request(byte_t data, logic first, logic last, logic seq);
        while ($urandom_range(99) < src_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.data_byte    <= data;
        in_ch.first_byte   <= first;
        in_ch.last_byte    <= last;
        in_ch.sequence_req <= seq;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    // Sender goes quiet until every owed byte is out.
    // Every request yields at least one byte, so an empty queue means idle.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (owed != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_one(logic [ifsf_pkg::CFG_IDX_W-1:0] idx, byte_t val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
    endtask

    // all six registers, only ever called with the block settled
    task automatic write_link(ifsf_pkg::cfg_t c);
        write_one(ifsf_pkg::REG_FLAG, c.flag_byte);
        write_one(ifsf_pkg::REG_ESCAPE, c.escape_byte);
        write_one(ifsf_pkg::REG_MASK, c.escape_mask);
        write_one(ifsf_pkg::REG_ADDRESS, c.address_byte);
        write_one(ifsf_pkg::REG_CTRL_SEQ0, c.control_seq0);
        write_one(ifsf_pkg::REG_CTRL_SEQ1, c.control_seq1);
        cfg.valid <= 1'b0;
        cur_cfg = c;
        settings++;
    endtask

    function automatic ifsf_pkg::cfg_t random_link();
        ifsf_pkg::cfg_t c;
        c.flag_byte    = byte_t'($urandom_range(255));
        c.escape_byte  = byte_t'($urandom_range(255));
        c.escape_mask  = byte_t'($urandom_range(255));
        c.address_byte = byte_t'($urandom_range(255));
        c.control_seq0 = byte_t'($urandom_range(255));
        c.control_seq1 = byte_t'($urandom_range(255));
        return c;
    endfunction

    // bias payload towards the values that need stuffing
    function automatic byte_t pick_byte();
        int roll;
        roll = int'($urandom_range(99));
        if (roll < 15)
            return cur_cfg.flag_byte;
        else if (roll < 30)
            return cur_cfg.escape_byte;
        else if (roll < 35)
            return (roll[0]) ? 8'hFF : 8'h00;
        else
            return byte_t'($urandom_range(255));
    endfunction

    // Mostly well-formed frames of random length with random content; about
    // one request in ten is noise with arbitrary first/last marks.
    task automatic random_frames(int count);
        int target;
        int len;
        target = sent + count;
        while (sent < target)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_request(pick_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                             1'($urandom_range(1)));
            end
            else
            begin
                len = ($urandom_range(7) == 0) ? int'($urandom_range(6, 16))
                                               : int'($urandom_range(1, 5));
                for (int k = 0; k < len; k++)
                    send_request(pick_byte(), k == 0, k == len - 1, 1'($urandom_range(1)));
            end
        end
    endtask

    initial
    begin
        ifsf_pkg::cfg_t c;

        sent      = 0;
        settings  = 1;
        src_idle  = 31;
        sink_idle = 71;
        cur_cfg   = '{flag_byte: ifsf_pkg::FLAG_RESET,
                      escape_byte: ifsf_pkg::ESCAPE_RESET,
                      escape_mask: ifsf_pkg::MASK_RESET,
                      address_byte: ifsf_pkg::ADDRESS_RESET,
                      control_seq0: ifsf_pkg::CTRL_SEQ0_RESET,
                      control_seq1: ifsf_pkg::CTRL_SEQ1_RESET};

        rst_n              <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.data_byte    <= '0;
        in_ch.first_byte   <= 1'b0;
        in_ch.last_byte    <= 1'b0;
        in_ch.sequence_req <= 1'b0;
        cfg.valid          <= 1'b0;
        cfg.index          <= '0;
        cfg.data           <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, reset register values ---
        // stray byte with no frame open; the sequence bit must be ignored
        send_request(8'h42, 1'b0, 1'b0, 1'b1);
        // single-byte frames: flag payload gives the longest burst (9 bytes)
        send_request(8'h7E, 1'b1, 1'b1, 1'b0);
        send_request(8'h7D, 1'b1, 1'b1, 1'b1);
        // longer frame, field extremes and both stuffed values mid-frame
        send_request(8'h00, 1'b1, 1'b0, 1'b1);
        send_request(8'hFF, 1'b0, 1'b0, 1'b0);
        send_request(8'h7E, 1'b0, 1'b0, 1'b1);
        send_request(8'h7D, 1'b0, 1'b0, 1'b0);
        send_request(8'hFF, 1'b0, 1'b1, 1'b0);
        // check byte lands on the flag, then on the escape
        send_request(8'h10, 1'b1, 1'b0, 1'b0);
        send_request(8'h6E, 1'b0, 1'b1, 1'b0);
        send_request(8'h01, 1'b1, 1'b0, 1'b1);
        send_request(8'h7C, 1'b0, 1'b1, 1'b1);
        // new first byte while a frame is open: fresh header, check restarts
        send_request(8'h11, 1'b1, 1'b0, 1'b0);
        send_request(8'h22, 1'b1, 1'b0, 1'b1);
        send_request(8'h33, 1'b0, 1'b1, 1'b0);
        // flag^mask is plain data
        send_request(8'h5E, 1'b1, 1'b1, 1'b0);
        // continuation after a close runs from a cleared check
        send_request(8'hA5, 1'b0, 1'b0, 1'b0);
        send_request(8'h5A, 1'b0, 1'b1, 1'b0);

        random_frames(110);

        // --- extremes: everything zero, then everything ones ---
        settle();
        write_link('{default: 8'h00});
        random_frames(60);

        settle();
        write_link('{default: 8'hFF});
        random_frames(60);

        // --- swap pacing; flag equal to escape, address byte equal to it too ---
        settle();
        src_idle  = 71;
        sink_idle = 31;
        c = random_link();
        c.flag_byte    = 8'h55;
        c.escape_byte  = 8'h55;
        c.address_byte = 8'h55;
        write_link(c);
        send_request(8'h55, 1'b1, 1'b1, 1'b1);
        send_request(8'h55, 1'b1, 1'b0, 1'b0);
        send_request(8'h00, 1'b0, 1'b1, 1'b0);
        send_request(8'hAA, 1'b1, 1'b1, 1'b1);
        random_frames(90);

        // --- full rate both sides, random registers, a full pause midway ---
        settle();
        src_idle  = 0;
        sink_idle = 0;
        write_link(random_link());
        random_frames(60);
        settle();
        write_link(random_link());
        random_frames(60);

        settle();
        repeat (20) @(posedge clk);

        $display("Ran %0d payload requests under %0d register settings and three pacing mixes.",
                 sent, settings);
        $display("Compared %0d line bytes including %0d closing flags.",
                 bytes_seen, frames_closed);
        if (faults == 0 && owed == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
sv/ifsf_pkg.sv
sv/ifsf_ifs.sv
sv/ifsf_front.sv
sv/ifsf_queue.sv
sv/ifsf_back.sv
sv/info_frame_stuffing_framer.sv
test/ifsf_checker.sv
test/testbench.sv
